### design/fpmso_pkg.sv
`timescale 1ns / 1ps
// fpmso_pkg: fixed widths, cordic types and the arctangent table for the
// feedback phase-modulated sine oscillator. depends on nothing.
package fpmso_pkg;

  localparam int FREQ_W = 24;
  localparam int GAIN_W = 16;
  localparam int CFG_W  = 28;

  localparam logic [CFG_W-1:0] PHASE_PER_HZ_RESET = 28'd22906492;

  // signed frequency times unsigned scale, with a spare sign bit
  localparam int STEP_PROD_W = FREQ_W + CFG_W + 1;

  localparam int CORDIC_STEPS = 30;
  localparam int ITER_W       = 5;
  localparam int CORDIC_W     = 34;

  typedef logic signed [CORDIC_W-1:0] cordic_t;
  typedef logic [ITER_W-1:0] iter_t;

  localparam cordic_t CORDIC_GAIN_Q30 = cordic_t'(652032874);
  localparam iter_t   LAST_ITER       = iter_t'(CORDIC_STEPS - 1);

  // atan(2^-i) as a fraction of a cycle, 32 fraction bits
  function automatic cordic_t atan_cycles(input iter_t idx);
    cordic_t a;
    case (idx)
      5'd0:    a = cordic_t'(536870912);
      5'd1:    a = cordic_t'(316933406);
      5'd2:    a = cordic_t'(167458907);
      5'd3:    a = cordic_t'(85004756);
      5'd4:    a = cordic_t'(42667331);
      5'd5:    a = cordic_t'(21354465);
      5'd6:    a = cordic_t'(10679838);
      5'd7:    a = cordic_t'(5340245);
      5'd8:    a = cordic_t'(2670163);
      5'd9:    a = cordic_t'(1335087);
      5'd10:   a = cordic_t'(667544);
      5'd11:   a = cordic_t'(333772);
      5'd12:   a = cordic_t'(166886);
      5'd13:   a = cordic_t'(83443);
      5'd14:   a = cordic_t'(41722);
      5'd15:   a = cordic_t'(20861);
      5'd16:   a = cordic_t'(10430);
      5'd17:   a = cordic_t'(5215);
      5'd18:   a = cordic_t'(2608);
      5'd19:   a = cordic_t'(1304);
      5'd20:   a = cordic_t'(652);
      5'd21:   a = cordic_t'(326);
      5'd22:   a = cordic_t'(163);
      5'd23:   a = cordic_t'(81);
      5'd24:   a = cordic_t'(41);
      5'd25:   a = cordic_t'(20);
      5'd26:   a = cordic_t'(10);
      5'd27:   a = cordic_t'(5);
      5'd28:   a = cordic_t'(3);
      5'd29:   a = cordic_t'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### design/feedback_phase_mod_sine_osc_unit.sv
`timescale 1ns / 1ps
// feedback_phase_mod_sine_osc_unit: feedback fm sine operator with a
// one-entry state memory and an iterative cordic. depends on fpmso_pkg.
//
// usage
//   input channel (in_valid / in_stall): one beat carries frequency_hz
//   (signed q16.8 hz) and feedback (signed q4.12 gain on the last output).
//   output channel (out_valid / out_stall): one beat carries sample, the
//   sine of phase plus feedback term, signed q1.15 at the default width.
//   config: cfg_write with cfg_data loads phase_per_hz (2^40 / sample rate)
//   at that clock edge; write it only while the block is idle.
// sequence
//   one item at a time: load from the state memory and the two multiplies,
//   phase set-up, then 30 cordic rotations on one shared shift-add unit,
//   one per cycle, then round and write back. the next beat is taken only
//   once write back is done and the sequencer is idle again.
// reset
//   rst (synchronous) clears the state valid flag, so phase and last output
//   read as zero, and loads phase_per_hz with its default.
// stalls
//   the result sits in the output register; a new beat is taken while it
//   waits. a finished item holds in its final step until that register
//   is free, and in_stall stays high meanwhile.
module feedback_phase_mod_sine_osc_unit import fpmso_pkg::*; #(
  parameter int PHASE_BITS  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [FREQ_W-1:0]      frequency_hz,
  input  logic signed [GAIN_W-1:0]      feedback,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample
);

  localparam int ENTRY_W   = PHASE_BITS + SAMPLE_BITS;
  localparam int FB_PROD_W = SAMPLE_BITS + GAIN_W;
  localparam int FB_EXT_W  = PHASE_BITS + FB_PROD_W;
  // product carries SAMPLE_BITS + 11 fraction bits, line it up with the phase
  localparam int FB_SHIFT  = PHASE_BITS - (SAMPLE_BITS + 11);
  localparam int ROUND_SH  = 31 - SAMPLE_BITS;
  localparam int SAMPLE_HI = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int SAMPLE_LO = -(1 << (SAMPLE_BITS - 1));

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_ROT  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]  state;
  iter_t       iter;
  logic [CFG_W-1:0] phase_per_hz;

  // captured beat
  logic signed [FREQ_W-1:0] freq_q;
  logic signed [GAIN_W-1:0] gain_q;

  // state memory: {phase_acc, last_output}, one entry, registered read
  logic [ENTRY_W-1:0] state_mem [1];
  logic [ENTRY_W-1:0] rd_data;
  logic               rd_hit;
  logic               state_valid;
  logic               mem_rd;
  logic               mem_we;
  logic [ENTRY_W-1:0] mem_wdata;

  logic [PHASE_BITS-1:0]         cur_phase;
  logic signed [SAMPLE_BITS-1:0] cur_last;

  // products, each registered before use
  logic signed [FB_PROD_W-1:0]   prod_fb;
  logic signed [STEP_PROD_W-1:0] prod_step;
  logic [PHASE_BITS-1:0]         phase_q;
  logic [PHASE_BITS-1:0]         phase_new;

  logic signed [FB_EXT_W-1:0] fb_ext;
  logic [PHASE_BITS-1:0]      fb_term;
  logic [PHASE_BITS-1:0]      theta;
  logic [PHASE_BITS-1:0]      step_term;
  logic [31:0]                t32;
  logic [31:0]                fold_a;
  logic                       fold_hi;

  // cordic unit
  cordic_t cx, cy, cz;
  cordic_t dx, dy, atan_i;
  cordic_t rot_x, rot_y, rot_z;
  cordic_t rounded;
  logic signed [SAMPLE_BITS-1:0] sat_sample;

  logic accept;
  logic commit;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign mem_rd   = accept;
  assign commit   = (state == S_FIN) && (!out_valid || !out_stall);
  assign mem_we   = commit;

  // an entry never written reads as the reset state, all zero
  assign cur_phase = rd_hit ? rd_data[ENTRY_W-1 -: PHASE_BITS] : '0;
  assign cur_last  = rd_hit ? signed'(rd_data[SAMPLE_BITS-1:0]) : '0;

  // feedback term, floor when shifted right, wrapped to one cycle
  assign fb_ext = FB_EXT_W'(prod_fb);
  generate
    if (FB_SHIFT >= 0) begin : g_fb_left
      assign fb_term = PHASE_BITS'(fb_ext <<< FB_SHIFT);
    end else begin : g_fb_right
      assign fb_term = PHASE_BITS'(fb_ext >>> (SAMPLE_BITS + 11 - PHASE_BITS));
    end
  endgenerate

  assign theta = phase_q + fb_term;

  generate
    if (PHASE_BITS >= 32) begin : g_t32_top
      assign t32 = theta[PHASE_BITS-1 -: 32];
    end else begin : g_t32_pad
      assign t32 = {theta, {(32 - PHASE_BITS){1'b0}}};
    end
  endgenerate

  // second and third quarter mirror about half a cycle
  assign fold_hi = t32[31] ^ t32[30];
  assign fold_a  = fold_hi ? (32'h8000_0000 - t32) : t32;

  // phase step: bits of the 2^(48 - PHASE_BITS) scaled product
  assign step_term = prod_step[47 -: PHASE_BITS];

  // one rotation
  assign dx     = cy >>> iter;
  assign dy     = cx >>> iter;
  assign atan_i = atan_cycles(iter);

  always_comb begin
    if (!cz[CORDIC_W-1]) begin
      rot_x = cx - dx;
      rot_y = cy + dy;
      rot_z = cz - atan_i;
    end else begin
      rot_x = cx + dx;
      rot_y = cy - dy;
      rot_z = cz + atan_i;
    end
  end

  // round half up to the sample grid, then clamp
  assign rounded = (cy + (cordic_t'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;

  always_comb begin
    if (rounded > cordic_t'(SAMPLE_HI)) begin
      sat_sample = SAMPLE_BITS'(SAMPLE_HI);
    end else if (rounded < cordic_t'(SAMPLE_LO)) begin
      sat_sample = SAMPLE_BITS'(SAMPLE_LO);
    end else begin
      sat_sample = rounded[SAMPLE_BITS-1:0];
    end
  end

  assign mem_wdata = {phase_new, sat_sample};

  // state memory array, no reset
  always_ff @(posedge clk) begin
    if (mem_we) begin
      state_mem[0] <= mem_wdata;
    end
    if (mem_rd) begin
      rd_data <= state_mem[0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      iter         <= '0;
      state_valid  <= 1'b0;
      rd_hit       <= 1'b0;
      out_valid    <= 1'b0;
      phase_per_hz <= PHASE_PER_HZ_RESET;
    end else begin
      if (cfg_write) begin
        phase_per_hz <= cfg_data;
      end
      if (mem_rd) begin
        rd_hit <= state_valid;
      end
      if (mem_we) begin
        state_valid <= 1'b1;
      end

      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          state <= S_PREP;
        end
        S_PREP: begin
          iter  <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (iter == LAST_ITER) begin
            state <= S_FIN;
          end else begin
            iter <= iter + iter_t'(1);
          end
        end
        S_FIN: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      freq_q <= frequency_hz;
      gain_q <= feedback;
    end
    if (state == S_LOAD) begin
      prod_fb   <= cur_last * gain_q;
      prod_step <= freq_q * signed'({1'b0, phase_per_hz});
      phase_q   <= cur_phase;
    end
    if (state == S_PREP) begin
      cx        <= CORDIC_GAIN_Q30;
      cy        <= '0;
      cz        <= cordic_t'(signed'(fold_a));
      phase_new <= phase_q + step_term;
    end
    if (state == S_ROT) begin
      cx <= rot_x;
      cy <= rot_y;
      cz <= rot_z;
    end
    if (commit) begin
      sample <= sat_sample;
    end
  end

  // checks
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_LOAD)
    else $error("accepted beat did not start a state read");

  a_iter_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ROT |-> iter <= LAST_ITER)
    else $error("rotation count out of range");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result raised outside the final step");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> state_valid)
    else $error("state write not marked valid");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample))
    else $error("waiting result overwritten");

endmodule

### tb/feedback_phase_mod_sine_osc_unit_tb.sv
`timescale 1ns / 1ps
// feedback_phase_mod_sine_osc_unit_tb: self-checking bench for the feedback fm sine
// operator, with its own bit-exact oscillator model and a queue of expected samples.
// depends on fpmso_pkg and feedback_phase_mod_sine_osc_unit.
module feedback_phase_mod_sine_osc_unit_tb;
  import fpmso_pkg::*;

  // run-away guard, far above the slowest legal run (~700 beats)
  localparam int CYCLE_LIMIT = 500000;
  // chance in a hundred that a side idles
  localparam int IDLE_PCT    = 28;
  // margin from the output register to the done flag
  localparam int DRAIN_CYCLES = 40;

  localparam logic signed [FREQ_W-1:0] FREQ_MAX = {1'b0, {(FREQ_W-1){1'b1}}};
  localparam logic signed [FREQ_W-1:0] FREQ_MIN = {1'b1, {(FREQ_W-1){1'b0}}};
  localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};
  localparam logic [CFG_W-1:0]         SCALE_MAX = {CFG_W{1'b1}};
  // 2^27 per hz with 2^19 (2048 hz) gives a step of exactly a quarter cycle
  localparam logic [CFG_W-1:0]         SCALE_QUARTER = 28'd134217728;
  localparam logic signed [FREQ_W-1:0] FREQ_QUARTER  = 24'sd524288;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [CFG_W-1:0]           cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [FREQ_W-1:0]   frequency_hz;
  logic signed [GAIN_W-1:0]   feedback;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [15:0]         sample;

  feedback_phase_mod_sine_osc_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .frequency_hz (frequency_hz),
    .feedback     (feedback),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample       (sample)
  );

  // oscillator model state, mirrors the block's phase, last output and scale
  logic [31:0]          osc_phase;
  logic signed [15:0]   osc_last;
  logic [CFG_W-1:0]     scale_per_hz;

  // arctangent of 2^-i in turns, 32 fraction bits
  longint atan_turns [0:29] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1
  };

  logic signed [15:0] expected_samples [$];
  logic signed [15:0] want;

  int  errors;
  int  beats_sent;
  int  samples_checked;
  int  scale_loads;
  int  cycles;
  // when set, neither side idles
  bit  steady;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("feedback_phase_mod_sine_osc_unit_tb NOT OK");
      $finish;
    end
  end

  // sine of a turn fraction in q1.15 by 30 cordic rotations, floor shifts throughout
  function automatic logic signed [15:0] cordic_sine(input logic [31:0] theta);
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    longint      r;
    logic [31:0] a;
    // fold the left half-plane onto [-1/4, 1/4] via sin(t) = sin(1/2 - t)
    if (theta >= 32'h4000_0000 && theta < 32'hC000_0000)
      a = 32'h8000_0000 - theta;
    else
      a = theta;
    x = 652032874;
    y = 0;
    z = longint'($signed(a));
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_turns[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_turns[i];
      end
    end
    // q30 down to q15, round half up, then clip (+1.0 lands on 32767)
    r = (y + longint'(16384)) >>> 15;
    if (r > 32767)
      r = 32767;
    if (r < -32768)
      r = -32768;
    return r[15:0];
  endfunction

  // one oscillator step: queue the sample, then move the phase on
  task automatic step_oscillator(input logic signed [FREQ_W-1:0] f,
                                 input logic signed [GAIN_W-1:0] g);
    logic [63:0]        fb_term;
    logic [63:0]        step;
    logic signed [15:0] s;
    // q1.15 times q4.12 has 27 fraction bits, 5 short of the phase width
    fb_term = 64'(longint'(osc_last) * longint'(g)) << 5;
    s = cordic_sine(osc_phase + fb_term[31:0]);
    osc_last = s;
    expected_samples.push_back(s);
    step = 64'(longint'(f) * longint'(scale_per_hz));
    osc_phase = osc_phase + step[47:16];
  endtask

  // one input beat, with an occasional gap ahead of it
  task automatic send_beat(input logic signed [FREQ_W-1:0] f,
                           input logic signed [GAIN_W-1:0] g);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < IDLE_PCT)
      gap = $urandom_range(1, 40);
    // random gaps land on every phase of the item
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    frequency_hz <= f;
    feedback     <= g;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    step_oscillator(f, g);
    beats_sent++;
  endtask

  // wait for every queued sample to come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0)
      @(posedge clk);
  endtask

  // load phase_per_hz while the block is idle
  task automatic load_scale(input logic [CFG_W-1:0] v);
    wait_drained();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    scale_per_hz = v;
    scale_loads++;
  endtask

  // straight after reset the phase is zero, so quarter-cycle steps hit the peaks
  task automatic test_full_scale();
    load_scale(SCALE_QUARTER);
    repeat (4)
      send_beat(FREQ_QUARTER, '0);
    // phase back at zero, now step backwards
    send_beat(-FREQ_QUARTER, '0);
  endtask

  // extremes of both input fields at the default scale
  task automatic test_field_extremes();
    load_scale(PHASE_PER_HZ_RESET);
    send_beat(FREQ_MAX, GAIN_MAX);
    send_beat(FREQ_MIN, GAIN_MIN);
    send_beat('0, GAIN_MAX);
    send_beat(-24'sd1, GAIN_MIN);
    send_beat(24'sd1, -16'sd1);
    send_beat(FREQ_MAX, '0);
    send_beat(FREQ_MIN, 16'sd1);
  endtask

  // zero scale freezes the phase, only the feedback path moves the output
  task automatic test_zero_scale();
    load_scale('0);
    send_beat(FREQ_MAX, 16'sd4096);
    send_beat(FREQ_MIN, -16'sd4096);
    send_beat(24'($urandom), GAIN_MAX);
    send_beat(24'($urandom), GAIN_MIN);
    send_beat(24'($urandom), '0);
  endtask

  // smallest and largest scale
  task automatic test_scale_extremes();
    load_scale(28'd1);
    send_beat(FREQ_MAX, 16'sd2048);
    send_beat(FREQ_MIN, -16'sd2048);
    load_scale(SCALE_MAX);
    send_beat(FREQ_MAX, '0);
    send_beat(FREQ_MIN, 16'sd512);
    send_beat(24'($urandom), 16'($urandom));
  endtask

  // random beat: mostly full range, the rest audio-like tones and mild feedback
  task automatic send_random_beat();
    logic signed [FREQ_W-1:0] f;
    logic signed [GAIN_W-1:0] g;
    if ($urandom_range(99) < 60) begin
      f = 24'($urandom);
      g = 16'($urandom);
    end else begin
      f = 24'($urandom_range(0, 10240000) - 5120000);
      g = 16'($urandom_range(0, 16383) - 8192);
    end
    send_beat(f, g);
  endtask

  // random beats over a spread of sample rates and random scales
  task automatic test_random_sweep(input int beats_per_setting);
    logic [CFG_W-1:0] settings [0:4];
    settings[0] = PHASE_PER_HZ_RESET;        // 48 khz
    settings[1] = 28'd24932236;              // 44.1 khz
    settings[2] = 28'd11453246;              // 96 khz
    settings[3] = CFG_W'($urandom_range(1, SCALE_MAX));
    settings[4] = CFG_W'($urandom_range(1, 65535));
    for (int k = 0; k < 5; k++) begin
      load_scale(settings[k]);
      repeat (beats_per_setting)
        send_random_beat();
    end
  endtask

  // back-to-back beats with no idling on either side
  task automatic test_steady_burst(input int beats);
    load_scale(CFG_W'($urandom_range(1, SCALE_MAX)));
    steady = 1'b1;
    repeat (beats)
      send_random_beat();
    wait_drained();
    steady = 1'b0;
  endtask

  // receiver stalls at random, never while steady
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // each output beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        $error("sample: nothing expected, got %0d", sample);
        errors++;
      end else begin
        want = expected_samples.pop_front();
        samples_checked++;
        if (sample !== want) begin
          $error("sample: expected %0d, got %0d", want, sample);
          errors++;
        end
      end
    end
  end

  initial begin
    errors          = 0;
    beats_sent      = 0;
    samples_checked = 0;
    scale_loads     = 0;
    cycles          = 0;
    steady          = 1'b0;
    osc_phase       = '0;
    osc_last        = '0;
    scale_per_hz    = PHASE_PER_HZ_RESET;
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    frequency_hz <= '0;
    feedback     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_full_scale();
    test_field_extremes();
    test_zero_scale();
    test_scale_extremes();
    test_random_sweep(100);
    test_steady_burst(150);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d beats in, %0d samples checked, %0d scale loads",
             beats_sent, samples_checked, scale_loads);
    $display("full scale, zero scale, field and scale extremes, random tones with stalls");
    if (errors == 0 && expected_samples.size() == 0)
      $display("feedback_phase_mod_sine_osc_unit_tb OK");
    else
      $display("feedback_phase_mod_sine_osc_unit_tb NOT OK");
    $finish;
  end

endmodule

### files.f
design/fpmso_pkg.sv
design/feedback_phase_mod_sine_osc_unit.sv
tb/feedback_phase_mod_sine_osc_unit_tb.sv
